// ===== design/iss_pkg.sv =====
// Package for the Indic syllable segmenter: widths, constants and the
// fixed transition table. Used by every module of the block.
package iss_pkg;

  localparam int MAP_DEPTH_DEF = 64;
  localparam int NSTATES = 42;
  localparam int NCLASSES = 24;
  localparam int CODE_W = 16;
  localparam int CLS_W = 5;
  localparam int ST_W = 6;
  localparam int CFG_W = 7;
  localparam int IDX_W = 6;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SEG = 1'b1;

  // reject code marks an empty cell of the transition table
  localparam logic [ST_W-1:0] ST_REJECT = 6'd63;
  localparam logic [ST_W-1:0] ST_BEGIN = 6'd0;
  localparam logic [ST_W-1:0] ST_ACCEPT = 6'd41;

  typedef logic [ST_W-1:0] st_t;

  // search request and answer between sequencer and search unit
  typedef struct packed {
    logic start;
    logic [CODE_W-1:0] code;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic [CLS_W-1:0] cls;
  } srch_rsp_t;

  // transition table, reject shown as ST_REJECT
  function automatic st_t next_state(input logic [ST_W-1:0] s, input logic [CLS_W-1:0] c);
    st_t r;
    logic [7:0] k;
    r = ST_REJECT;
    k = {s[5:0], 2'b00};
    case (s)
      6'd0: case (c)
        5'd0, 5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd12, 5'd13, 5'd14, 5'd18, 5'd19,
        5'd20: r = 6'd41;
        5'd2: r = 6'd5; 5'd3: r = 6'd1; 5'd8: r = 6'd11; 5'd9: r = 6'd15;
        5'd11: r = 6'd21; 5'd15: r = 6'd23; 5'd16: r = 6'd24; 5'd17: r = 6'd25;
        5'd21: r = 6'd26; 5'd22: r = 6'd32; 5'd23: r = 6'd1;
        default: r = ST_REJECT;
      endcase
      6'd1, 6'd2, 6'd3, 6'd4, 6'd11, 6'd12, 6'd13, 6'd14, 6'd21: case (c)
        5'd1: r = 6'd41;
        5'd4, 5'd10, 5'd13, 5'd14, 5'd18, 5'd19, 5'd20: r = 6'd10;
        5'd5: r = (s == 6'd1 || s == 6'd11 || s == 6'd21) ? 6'd6 :
                  (s == 6'd2 || s == 6'd12) ? 6'd7 :
                  (s == 6'd3 || s == 6'd13) ? 6'd8 : 6'd9;
        5'd6: r = (s == 6'd1 || s == 6'd21) ? 6'd11 : (s == 6'd2) ? 6'd12 :
                  (s == 6'd3) ? 6'd13 : (s == 6'd4) ? 6'd14 : ST_REJECT;
        5'd7: r = (s == 6'd21) ? 6'd16 : ST_REJECT;
        5'd12: r = 6'd22;
        default: r = ST_REJECT;
      endcase
      6'd5: r = (c == 5'd1) ? 6'd41 : (c == 5'd14) ? 6'd10 : ST_REJECT;
      6'd6, 6'd7, 6'd8, 6'd18, 6'd19, 6'd20: begin
        case (c)
          5'd1: r = (s >= 6'd18) ? 6'd41 : ST_REJECT;
          5'd3, 5'd11, 5'd23: r = (s == 6'd6 || s == 6'd18) ? 6'd2 :
                                  (s == 6'd7 || s == 6'd19) ? 6'd3 : 6'd4;
          5'd7: r = (s == 6'd6) ? 6'd18 : (s == 6'd7) ? 6'd19 :
                    (s == 6'd8) ? 6'd20 : ST_REJECT;
          5'd8: r = (s == 6'd6 || s == 6'd18) ? 6'd12 :
                    (s == 6'd7 || s == 6'd19) ? 6'd13 : 6'd14;
          5'd21: r = (s == 6'd6 || s == 6'd18) ? 6'd27 :
                     (s == 6'd7 || s == 6'd19) ? 6'd28 : 6'd4;
          5'd22: r = (s == 6'd6 || s == 6'd18) ? 6'd33 :
                     (s == 6'd7 || s == 6'd19) ? 6'd34 : 6'd4;
          default: r = ST_REJECT;
        endcase
      end
      6'd9: r = (c == 5'd7) ? 6'd41 : ST_REJECT;
      6'd10: r = (c == 5'd1) ? 6'd41 : ST_REJECT;
      6'd15: case (c)
        5'd1: r = 6'd41; 5'd7: r = 6'd17;
        5'd10, 5'd14, 5'd18, 5'd19, 5'd20: r = 6'd10;
        default: r = ST_REJECT;
      endcase
      6'd16: r = (c == 5'd5) ? 6'd6 : ST_REJECT;
      6'd17: r = (c == 5'd10) ? 6'd41 : ST_REJECT;
      6'd22: r = (c == 5'd1) ? 6'd41 : (c == 5'd13 || c == 5'd14) ? 6'd10 : ST_REJECT;
      6'd23: r = (c == 5'd1) ? 6'd41 : (c == 5'd18) ? 6'd5 : ST_REJECT;
      6'd24: r = (c == 5'd19) ? 6'd5 : ST_REJECT;
      6'd25: r = (c == 5'd20) ? 6'd5 : ST_REJECT;
      6'd26, 6'd27, 6'd28, 6'd32, 6'd33, 6'd34: case (c)
        5'd1: r = 6'd41;
        5'd4, 5'd13, 5'd14: r = 6'd10;
        5'd12: r = 6'd22;
        5'd5: r = (s == 6'd26) ? 6'd29 : (s == 6'd27) ? 6'd30 : (s == 6'd28) ? 6'd31 :
                  (s == 6'd32) ? 6'd35 : (s == 6'd33) ? 6'd36 : 6'd37;
        default: r = ST_REJECT;
      endcase
      6'd29, 6'd30, 6'd31, 6'd35, 6'd36, 6'd37: case (c)
        5'd3, 5'd23: r = (s == 6'd29 || s == 6'd35) ? 6'd2 :
                         (s == 6'd30 || s == 6'd36) ? 6'd3 : 6'd4;
        5'd21: r = (s == 6'd29 || s == 6'd35) ? 6'd27 :
                   (s == 6'd30 || s == 6'd36) ? 6'd28 : 6'd4;
        5'd22: r = (s == 6'd29 || s == 6'd35) ? 6'd33 :
                   (s == 6'd30 || s == 6'd36) ? 6'd34 : 6'd4;
        5'd7: r = (s == 6'd35) ? 6'd38 : (s == 6'd36) ? 6'd39 :
                  (s == 6'd37) ? 6'd40 : 6'd41;
        default: r = ST_REJECT;
      endcase
      6'd38: r = (c == 5'd23) ? 6'd2 : ST_REJECT;
      6'd39: r = (c == 5'd23) ? 6'd3 : ST_REJECT;
      6'd40: r = (c == 5'd23) ? 6'd4 : ST_REJECT;
      default: r = ST_REJECT;
    endcase
    if (k == 8'hff) r = ST_REJECT;
    return r;
  endfunction

endpackage

// ===== design/iss_search.sv =====
// Range table memory and binary search unit; a new search starts only once the last is done.
// Depends on iss_pkg.
module iss_search #(
  parameter int MAP_DEPTH = iss_pkg::MAP_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  logic [iss_pkg::IDX_W-1:0] wr_idx,
  input  logic [iss_pkg::CODE_W-1:0] wr_code,
  input  logic [iss_pkg::CLS_W-1:0] wr_cls,
  input  logic [iss_pkg::CFG_W-1:0] map_entries,
  input  iss_pkg::srch_req_t req,
  output iss_pkg::srch_rsp_t rsp
);
  localparam int AW = $clog2(MAP_DEPTH);

  logic [iss_pkg::CODE_W-1:0] code_mem [MAP_DEPTH];
  logic [iss_pkg::CLS_W-1:0] cls_mem [MAP_DEPTH];
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [AW:0] sum;
  logic [iss_pkg::CODE_W-1:0] rd_code_r;
  logic [iss_pkg::CLS_W-1:0] rd_cls_r;
  logic [1:0] ph_r, ph_nxt;
  logic [iss_pkg::CODE_W-1:0] key_r;
  logic [AW-1:0] last;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_CMP = 2'd2;
  localparam logic [1:0] PH_OUT = 2'd3;

  // clamp the entry count to 1..MAP_DEPTH
  always_comb begin
    if (map_entries == '0) last = '0;
    else if (32'(map_entries) > MAP_DEPTH) last = AW'(MAP_DEPTH - 1);
    else last = AW'(32'(map_entries) - 32'd1);
  end

  assign sum = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
  assign mid = sum[AW:1];

  // table write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en && 32'(wr_idx) < MAP_DEPTH) begin
      code_mem[AW'(wr_idx)] <= wr_code;
      cls_mem[AW'(wr_idx)] <= wr_cls;
    end
    rd_code_r <= code_mem[mid];
    rd_cls_r <= cls_mem[lo_r];
  end

  // search sequencer: read mid, then compare and narrow
  always_comb begin
    ph_nxt = ph_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    case (ph_r)
      PH_IDLE: if (req.start) begin
        lo_nxt = '0;
        hi_nxt = last;
        ph_nxt = PH_READ;
      end
      PH_READ: ph_nxt = (lo_r == hi_r) ? PH_OUT : PH_CMP;
      PH_CMP: begin
        if (rd_code_r <= key_r) lo_nxt = mid;
        else hi_nxt = mid - 1'b1;
        ph_nxt = PH_READ;
      end
      PH_OUT: ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= PH_IDLE;
    else ph_r <= ph_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (ph_r == PH_IDLE && req.start) key_r <= req.code;
  end

  assign rsp.done = (ph_r == PH_OUT);
  assign rsp.cls = rd_cls_r;

`ifndef ASSERT_OFF
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == PH_CMP |-> lo_r <= hi_r) else $error("search bounds crossed");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> ph_r == PH_IDLE) else $error("search did not return idle");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_IDLE && req.start) |=> ph_r == PH_READ) else $error("search not started");
`endif
endmodule

// ===== design/indic_syllable_segmenter_core.sv =====
// Top level of the Indic syllable segmenter: handshake, sequencer and state.
// Depends on iss_pkg and iss_search.
//
//  channel  | handshake            | payload
//  in_      | in_valid / in_ready  | func, entry_index, range_first_code, range_class,
//           |                      | char_code, end_of_text
//  out_     | out_valid / out_ready| syllable_start, char_class, state_after
//  cfg_     | cfg_we               | cfg_data (map_entries)
//
// a load beat writes the range table and goes straight to output; a character is looked
// up by the binary search unit, then its result is registered.
// the result stays in the output register until taken; no new beat meanwhile.
// reset (synchronous, rst_n low) sets begin state, first-char flag and map_entries=1.
module indic_syllable_segmenter_core #(
  parameter int MAP_DEPTH = iss_pkg::MAP_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_func,
  input  logic [5:0] in_entry_index,
  input  logic [15:0] in_range_first_code,
  input  logic [4:0] in_range_class,
  input  logic [15:0] in_char_code,
  input  logic in_end_of_text,
  output logic out_valid,
  input  logic out_ready,
  output logic out_syllable_start,
  output logic [4:0] out_char_class,
  output logic [5:0] out_state_after,
  input  logic cfg_we,
  input  logic [6:0] cfg_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [6:0] map_entries_r;
  logic [5:0] syl_r;
  logic first_r;
  logic eot_r;
  logic start_r;
  logic [4:0] cls_r;
  logic [5:0] res_st_r;
  logic acc;
  iss_pkg::srch_req_t req;
  iss_pkg::srch_rsp_t rsp;
  logic [4:0] tc;
  logic [5:0] cur, n_cur, n_beg, n_sel;
  logic rej;

  assign acc = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_syllable_start = start_r;
  assign out_char_class = cls_r;
  assign out_state_after = res_st_r;

  assign req.start = acc && in_func == iss_pkg::FUNC_SEG;
  assign req.code = in_char_code;

  iss_search #(.MAP_DEPTH(MAP_DEPTH)) u_search (
    .clk(clk), .rst_n(rst_n),
    .wr_en(acc && in_func == iss_pkg::FUNC_LOAD),
    .wr_idx(in_entry_index), .wr_code(in_range_first_code), .wr_cls(in_range_class),
    .map_entries(map_entries_r), .req(req), .rsp(rsp));

  // transition step with replay from begin on reject
  always_comb begin
    tc = (rsp.cls < 5'(iss_pkg::NCLASSES)) ? rsp.cls : 5'd0;
    cur = (syl_r < 6'(iss_pkg::NSTATES)) ? syl_r : iss_pkg::ST_BEGIN;
    n_cur = iss_pkg::next_state(cur, tc);
    n_beg = iss_pkg::next_state(iss_pkg::ST_BEGIN, tc);
    rej = first_r || n_cur == iss_pkg::ST_REJECT;
    n_sel = rej ? n_beg : n_cur;
    if (n_sel == iss_pkg::ST_REJECT) n_sel = iss_pkg::ST_BEGIN;
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (acc) st_nxt = (in_func == iss_pkg::FUNC_SEG) ? S_SRCH : S_OUT;
      S_SRCH: if (rsp.done) st_nxt = S_OUT;
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      map_entries_r <= 7'd1;
      syl_r <= iss_pkg::ST_BEGIN;
      first_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) map_entries_r <= cfg_data;
      if (st_r == S_SRCH && rsp.done) begin
        syl_r <= eot_r ? iss_pkg::ST_BEGIN : n_sel;
        first_r <= eot_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (acc) begin
      eot_r <= in_end_of_text;
      start_r <= 1'b0;
      cls_r <= '0;
      res_st_r <= syl_r;
    end else if (st_r == S_SRCH && rsp.done) begin
      start_r <= rej;
      cls_r <= rsp.cls;
      res_st_r <= n_sel;
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_state_after))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    syl_r < 6'(iss_pkg::NSTATES)) else $error("state out of range");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> syl_r == iss_pkg::ST_BEGIN) else $error("first char not at begin");
`endif
endmodule
